// ===== rtl/core/dwps_pkg.sv =====
// Package for the dual-wheel incremental PI speed controller.
// Holds field widths, limits, register indexes, key codes and control types.
// No dependencies; every other file of the block imports it.
package dwps_pkg;

    // Field widths
    localparam int KEY_W       = 2;
    localparam int COUNT_W     = 16;
    localparam int TARGET_W    = 23;
    localparam int BIAS_W      = 14;
    localparam int BIAS_SUM_W  = 15;
    localparam int GAIN_W      = 16;
    localparam int SCALE_W     = 18;
    localparam int SPEED_W     = 24;
    localparam int ERR_W       = 26;
    localparam int ACC_STATE_W = 35;
    localparam int PROD_W      = 44;
    localparam int ACC_FRAC    = 20;
    localparam int DRIVE_W     = 14;
    localparam int DRV_SUM_W   = 17;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;
    localparam int BIT_CNT_W   = 4;

    // Limits
    localparam int DRIVE_LIMIT = 7800;
    localparam int MODE_COUNT  = 4;

    localparam longint ACC_LIMIT_L = longint'(DRIVE_LIMIT) <<< ACC_FRAC;
    localparam logic signed [PROD_W-1:0] ACC_LIMIT     = PROD_W'(ACC_LIMIT_L);
    localparam logic signed [PROD_W-1:0] ACC_LIMIT_NEG = -PROD_W'(ACC_LIMIT_L);

    localparam logic signed [PROD_W-1:0] SPEED_MAX = PROD_W'((longint'(1) <<< (SPEED_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SPEED_MIN = -PROD_W'(longint'(1) <<< (SPEED_W - 1));

    localparam logic signed [DRV_SUM_W-1:0] DRIVE_MAX = DRV_SUM_W'(DRIVE_LIMIT);
    localparam logic signed [DRV_SUM_W-1:0] DRIVE_MIN = -DRV_SUM_W'(DRIVE_LIMIT);

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P_LEFT       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I_LEFT       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P_RIGHT      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I_RIGHT      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_LEFT        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_RIGHT       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_STATIC_BIAS_LEFT  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_STATIC_BIAS_RIGHT = 3'd7;

    // Register reset values
    localparam logic [GAIN_W-1:0]         RST_GAIN_P_LEFT       = 16'd8000;
    localparam logic [GAIN_W-1:0]         RST_GAIN_I_LEFT       = 16'd11200;
    localparam logic [GAIN_W-1:0]         RST_GAIN_P_RIGHT      = 16'd12800;
    localparam logic [GAIN_W-1:0]         RST_GAIN_I_RIGHT      = 16'd25600;
    localparam logic signed [SCALE_W-1:0] RST_SCALE_LEFT        = 18'sd1024;
    localparam logic signed [SCALE_W-1:0] RST_SCALE_RIGHT       = 18'sd1024;
    localparam logic signed [BIAS_W-1:0]  RST_STATIC_BIAS_LEFT  = 14'sd0;
    localparam logic signed [BIAS_W-1:0]  RST_STATIC_BIAS_RIGHT = 14'sd1000;

    // Key event codes
    localparam logic [KEY_W-1:0] KEY_NONE   = 2'd0;
    localparam logic [KEY_W-1:0] KEY_SINGLE = 2'd1;
    localparam logic [KEY_W-1:0] KEY_DOUBLE = 2'd2;
    localparam logic [KEY_W-1:0] KEY_LONG   = 2'd3;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPEED,
        ST_ERROR,
        ST_PROP,
        ST_INTEG_SETUP,
        ST_INTEG,
        ST_CLAMP,
        ST_DRIVE,
        ST_DONE
    } state_t;

    // Operation issued to both wheel lanes each cycle
    typedef enum logic [3:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SPEED,
        OP_ERROR,
        OP_PROP,
        OP_INTEG_SETUP,
        OP_INTEG,
        OP_CLAMP,
        OP_DRIVE
    } lane_op_t;

    typedef struct packed {
        lane_op_t op;
        logic     last_bit;
        logic     stopped;
    } lane_ctrl_t;

endpackage

// ===== rtl/core/dwps_tick_if.sv =====
// Request channel carrying one control tick into the speed controller.
// Depends on dwps_pkg for the field widths.
interface dwps_tick_if
    import dwps_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [KEY_W-1:0]           key_event;
    logic signed [COUNT_W-1:0]  count_left;
    logic signed [COUNT_W-1:0]  count_right;
    logic signed [TARGET_W-1:0] target_left;
    logic signed [TARGET_W-1:0] target_right;
    logic signed [BIAS_W-1:0]   runtime_bias_left;
    logic signed [BIAS_W-1:0]   runtime_bias_right;

    modport source (
        output valid, key_event, count_left, count_right, target_left, target_right,
               runtime_bias_left, runtime_bias_right,
        input  ready
    );

    modport sink (
        input  valid, key_event, count_left, count_right, target_left, target_right,
               runtime_bias_left, runtime_bias_right,
        output ready
    );
endinterface

// ===== rtl/core/dwps_result_if.sv =====
// Request channel carrying one result of the speed controller per tick.
// Depends on dwps_pkg for the field widths.
interface dwps_result_if
    import dwps_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive_left;
    logic signed [DRIVE_W-1:0] drive_right;
    logic signed [SPEED_W-1:0] speed_left;
    logic signed [SPEED_W-1:0] speed_right;
    logic                      stopped;
    logic [MODE_W-1:0]         route_mode;

    modport source (
        output valid, drive_left, drive_right, speed_left, speed_right, stopped, route_mode,
        input  ready
    );

    modport sink (
        input  valid, drive_left, drive_right, speed_left, speed_right, stopped, route_mode,
        output ready
    );
endinterface

// ===== rtl/core/dual_wheel_incremental_pi_speed.sv =====
// Dual-wheel incremental PI speed controller, top level.
//
// Usage:
//   tick   - request channel, one 10 ms control tick per request: key event,
//            both encoder counts, both target speeds and runtime biases.
//   result - request channel, one result per tick: both drive values, both
//            measured speeds, the stop flag and the run mode.
//   cfg_*  - write port for gains, speed scales and static biases; write it
//            only while no tick is in progress.
// A new tick is accepted only once the sequencer is back in idle and the
// previous tick has left the lanes. Each wheel lane has a one-bit-per-
// cycle shift-add multiplier that makes three 16-step passes per tick (speed
// product, proportional term, integral term); both lanes run side by side.
// A finished result sits in an output register; tick.ready is high again
// once the lanes are free, even while that result waits to be taken. If the
// previous result is still unclaimed when the next finishes, the sequencer
// holds until the receiver takes it.
// Reset: the vehicle starts stopped in run mode 0 with both accumulators and
// previous errors at zero, and the registers at their default values.
module dual_wheel_incremental_pi_speed
    import dwps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    dwps_tick_if.sink              tick,
    dwps_result_if.source          result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic [GAIN_W-1:0]         gain_p_left_reg, gain_i_left_reg;
    logic [GAIN_W-1:0]         gain_p_right_reg, gain_i_right_reg;
    logic signed [SCALE_W-1:0] scale_left_reg, scale_right_reg;
    logic signed [BIAS_W-1:0]  static_bias_left_reg, static_bias_right_reg;

    // Sequencer and mode state
    state_t               state_reg, state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                 stop_reg, stop_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic                 out_valid_reg, out_valid_next;

    // Result register
    logic signed [DRIVE_W-1:0] out_drive_left_reg, out_drive_left_next;
    logic signed [DRIVE_W-1:0] out_drive_right_reg, out_drive_right_next;
    logic signed [SPEED_W-1:0] out_speed_left_reg, out_speed_left_next;
    logic signed [SPEED_W-1:0] out_speed_right_reg, out_speed_right_next;
    logic                      out_stopped_reg, out_stopped_next;
    logic [MODE_W-1:0]         out_mode_reg, out_mode_next;

    lane_ctrl_t                lane_ctrl;
    logic                      tick_accept;
    logic                      last_bit;
    logic signed [DRIVE_W-1:0] drive_left, drive_right;
    logic signed [SPEED_W-1:0] speed_left, speed_right;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_left_reg       <= RST_GAIN_P_LEFT;
            gain_i_left_reg       <= RST_GAIN_I_LEFT;
            gain_p_right_reg      <= RST_GAIN_P_RIGHT;
            gain_i_right_reg      <= RST_GAIN_I_RIGHT;
            scale_left_reg        <= RST_SCALE_LEFT;
            scale_right_reg       <= RST_SCALE_RIGHT;
            static_bias_left_reg  <= RST_STATIC_BIAS_LEFT;
            static_bias_right_reg <= RST_STATIC_BIAS_RIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_P_LEFT:       gain_p_left_reg       <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I_LEFT:       gain_i_left_reg       <= cfg_data[GAIN_W-1:0];
                REG_GAIN_P_RIGHT:      gain_p_right_reg      <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I_RIGHT:      gain_i_right_reg      <= cfg_data[GAIN_W-1:0];
                REG_SCALE_LEFT:        scale_left_reg        <= cfg_data[SCALE_W-1:0];
                REG_SCALE_RIGHT:       scale_right_reg       <= cfg_data[SCALE_W-1:0];
                REG_STATIC_BIAS_LEFT:  static_bias_left_reg  <= cfg_data[BIAS_W-1:0];
                REG_STATIC_BIAS_RIGHT: static_bias_right_reg <= cfg_data[BIAS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            stop_reg      <= 1'b1;
            mode_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            stop_reg      <= stop_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        out_drive_left_reg  <= out_drive_left_next;
        out_drive_right_reg <= out_drive_right_next;
        out_speed_left_reg  <= out_speed_left_next;
        out_speed_right_reg <= out_speed_right_next;
        out_stopped_reg     <= out_stopped_next;
        out_mode_reg        <= out_mode_next;
    end

    assign tick_accept = tick.valid && tick.ready;
    assign last_bit    = (bit_cnt_reg == {BIT_CNT_W{1'b1}});

    // Sequencer: key handling, lane operations and result hand-off.
    always_comb
    begin
        state_next           = state_reg;
        bit_cnt_next         = bit_cnt_reg;
        stop_next            = stop_reg;
        mode_next            = mode_reg;
        out_valid_next       = out_valid_reg;
        out_drive_left_next  = out_drive_left_reg;
        out_drive_right_next = out_drive_right_reg;
        out_speed_left_next  = out_speed_left_reg;
        out_speed_right_next = out_speed_right_reg;
        out_stopped_next     = out_stopped_reg;
        out_mode_next        = out_mode_reg;
        lane_ctrl.op         = OP_HOLD;
        lane_ctrl.last_bit   = last_bit;
        lane_ctrl.stopped    = stop_reg;

        // The receiver takes the waiting result.
        if (result.valid && result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (tick_accept)
                begin
                    lane_ctrl.op = OP_LOAD;
                    bit_cnt_next = '0;
                    state_next   = ST_SPEED;
                    if (tick.key_event == KEY_SINGLE || tick.key_event == KEY_LONG)
                        stop_next = !stop_reg;
                    else if (tick.key_event == KEY_DOUBLE && stop_reg)
                        mode_next = (mode_reg == MODE_W'(MODE_COUNT - 1)) ?
                                    '0 : mode_reg + MODE_W'(1);
                end
            end
            ST_SPEED:
            begin
                lane_ctrl.op = OP_SPEED;
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (last_bit)
                    state_next = ST_ERROR;
            end
            ST_ERROR:
            begin
                lane_ctrl.op = OP_ERROR;
                bit_cnt_next = '0;
                state_next   = ST_PROP;
            end
            ST_PROP:
            begin
                lane_ctrl.op = OP_PROP;
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (last_bit)
                    state_next = ST_INTEG_SETUP;
            end
            ST_INTEG_SETUP:
            begin
                lane_ctrl.op = OP_INTEG_SETUP;
                bit_cnt_next = '0;
                state_next   = ST_INTEG;
            end
            ST_INTEG:
            begin
                lane_ctrl.op = OP_INTEG;
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (last_bit)
                    state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                lane_ctrl.op = OP_CLAMP;
                state_next   = ST_DRIVE;
            end
            ST_DRIVE:
            begin
                lane_ctrl.op = OP_DRIVE;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // Hand over once the result register is free or being emptied.
                if (!result.valid || result.ready)
                begin
                    out_valid_next       = 1'b1;
                    out_drive_left_next  = drive_left;
                    out_drive_right_next = drive_right;
                    out_speed_left_next  = speed_left;
                    out_speed_right_next = speed_right;
                    out_stopped_next     = stop_reg;
                    out_mode_next        = mode_reg;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Wheel lanes, run in lockstep.
    dwps_wheel u_wheel_left (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (lane_ctrl),
        .count        (tick.count_left),
        .target       (tick.target_left),
        .runtime_bias (tick.runtime_bias_left),
        .static_bias  (static_bias_left_reg),
        .scale        (scale_left_reg),
        .gain_p       (gain_p_left_reg),
        .gain_i       (gain_i_left_reg),
        .drive        (drive_left),
        .speed        (speed_left)
    );

    dwps_wheel u_wheel_right (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (lane_ctrl),
        .count        (tick.count_right),
        .target       (tick.target_right),
        .runtime_bias (tick.runtime_bias_right),
        .static_bias  (static_bias_right_reg),
        .scale        (scale_right_reg),
        .gain_p       (gain_p_right_reg),
        .gain_i       (gain_i_right_reg),
        .drive        (drive_right),
        .speed        (speed_right)
    );

    // Channel outputs.
    assign tick.ready         = (state_reg == ST_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.drive_left  = out_drive_left_reg;
    assign result.drive_right = out_drive_right_reg;
    assign result.speed_left  = out_speed_left_reg;
    assign result.speed_right = out_speed_right_reg;
    assign result.stopped     = out_stopped_reg;
    assign result.route_mode  = out_mode_reg;

endmodule

// ===== rtl/core/dwps_wheel.sv =====
// One wheel lane: bit-serial speed product, incremental PI step and drive shaping.
// Depends on dwps_pkg; sequenced by the top level through a lane_ctrl_t word.
module dwps_wheel
    import dwps_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  lane_ctrl_t                 ctrl,
    input  logic signed [COUNT_W-1:0]  count,
    input  logic signed [TARGET_W-1:0] target,
    input  logic signed [BIAS_W-1:0]   runtime_bias,
    input  logic signed [BIAS_W-1:0]   static_bias,
    input  logic signed [SCALE_W-1:0]  scale,
    input  logic [GAIN_W-1:0]          gain_p,
    input  logic [GAIN_W-1:0]          gain_i,
    output logic signed [DRIVE_W-1:0]  drive,
    output logic signed [SPEED_W-1:0]  speed
);

    // Controller state
    logic signed [ACC_STATE_W-1:0] acc_reg, acc_next;
    logic signed [ERR_W-1:0]       prev_reg, prev_next;

    // Shift-add datapath and captured operands
    logic signed [PROD_W-1:0]     prod_reg, prod_next;
    logic signed [PROD_W-1:0]     mcand_reg, mcand_next;
    logic [GAIN_W-1:0]            mplier_reg, mplier_next;
    logic signed [TARGET_W-1:0]   target_reg, target_next;
    logic signed [BIAS_SUM_W-1:0] bias_reg, bias_next;
    logic signed [SPEED_W-1:0]    speed_reg, speed_next;
    logic signed [DRIVE_W-1:0]    drive_reg, drive_next;

    // State registers cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            prev_reg <= prev_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        target_reg <= target_next;
        bias_reg   <= bias_next;
        speed_reg  <= speed_next;
        drive_reg  <= drive_next;
    end

    // Next-state logic for each lane operation.
    always_comb
    begin
        logic signed [SPEED_W-1:0]     speed_sat;
        logic signed [ERR_W-1:0]       err;
        logic signed [ERR_W-1:0]       diff;
        logic signed [PROD_W-1:0]      acc_clamped;
        logic [ACC_STATE_W-1:0]        acc_mag;
        logic [ACC_STATE_W-ACC_FRAC-1:0] pwm_mag;
        logic signed [DRV_SUM_W-1:0]   pwm_pos;
        logic signed [DRV_SUM_W-1:0]   pwm;
        logic signed [DRV_SUM_W-1:0]   bias_ext;
        logic signed [DRV_SUM_W-1:0]   pwm_biased;
        logic signed [DRV_SUM_W-1:0]   pwm_clamped;

        acc_next    = acc_reg;
        prev_next   = prev_reg;
        prod_next   = prod_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        target_next = target_reg;
        bias_next   = bias_reg;
        speed_next  = speed_reg;
        drive_next  = drive_reg;

        // Saturate the measured speed and form the error terms.
        if (prod_reg > SPEED_MAX)
            speed_sat = SPEED_MAX[SPEED_W-1:0];
        else if (prod_reg < SPEED_MIN)
            speed_sat = SPEED_MIN[SPEED_W-1:0];
        else
            speed_sat = prod_reg[SPEED_W-1:0];
        err  = ERR_W'(target_reg) - ERR_W'(speed_sat);
        diff = err - prev_reg;

        // Clamp the new accumulator; a stopped tick zeroes it.
        if (ctrl.stopped)
            acc_clamped = '0;
        else if (prod_reg > ACC_LIMIT)
            acc_clamped = ACC_LIMIT;
        else if (prod_reg < ACC_LIMIT_NEG)
            acc_clamped = ACC_LIMIT_NEG;
        else
            acc_clamped = prod_reg;

        // Truncate toward zero, push away from zero by the bias, then clamp.
        acc_mag  = acc_reg[ACC_STATE_W-1] ? ACC_STATE_W'(-acc_reg) : ACC_STATE_W'(acc_reg);
        pwm_mag  = acc_mag[ACC_STATE_W-1:ACC_FRAC];
        pwm_pos  = signed'(DRV_SUM_W'(pwm_mag));
        pwm      = acc_reg[ACC_STATE_W-1] ? -pwm_pos : pwm_pos;
        bias_ext = DRV_SUM_W'(bias_reg);
        if (pwm_mag == '0)
            pwm_biased = '0;
        else if (acc_reg[ACC_STATE_W-1])
            pwm_biased = pwm - bias_ext;
        else
            pwm_biased = pwm + bias_ext;
        if (pwm_biased > DRIVE_MAX)
            pwm_clamped = DRIVE_MAX;
        else if (pwm_biased < DRIVE_MIN)
            pwm_clamped = DRIVE_MIN;
        else
            pwm_clamped = pwm_biased;

        case (ctrl.op)
            OP_LOAD:
            begin
                prod_next   = '0;
                mcand_next  = PROD_W'(scale);
                mplier_next = GAIN_W'($unsigned(count));
                target_next = target;
                bias_next   = BIAS_SUM_W'(runtime_bias) + BIAS_SUM_W'(static_bias);
            end
            OP_SPEED:
            begin
                // The count's top bit carries negative weight.
                if (mplier_reg[0])
                begin
                    if (ctrl.last_bit)
                        prod_next = prod_reg - mcand_reg;
                    else
                        prod_next = prod_reg + mcand_reg;
                end
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
            end
            OP_ERROR:
            begin
                speed_next  = speed_sat;
                prev_next   = err;
                prod_next   = PROD_W'(acc_reg);
                mcand_next  = PROD_W'(diff);
                mplier_next = gain_p;
            end
            OP_PROP, OP_INTEG:
            begin
                if (mplier_reg[0])
                    prod_next = prod_reg + mcand_reg;
                mcand_next  = mcand_reg <<< 1;
                mplier_next = mplier_reg >> 1;
            end
            OP_INTEG_SETUP:
            begin
                // The previous-error register now holds this tick's error.
                mcand_next  = PROD_W'(prev_reg);
                mplier_next = gain_i;
            end
            OP_CLAMP:
            begin
                acc_next = acc_clamped[ACC_STATE_W-1:0];
            end
            OP_DRIVE:
            begin
                drive_next = ctrl.stopped ? '0 : pwm_clamped[DRIVE_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign drive = drive_reg;
    assign speed = speed_reg;

endmodule
